// ===== hw/rtl/vdd_pkg.sv =====
// Shared types and constants for the vertex dedup and index remap block.
`timescale 1ns / 1ps

package vdd_pkg;

   localparam int DEF_MAX_DISTINCT = 1024;
   localparam int DEF_MAX_INPUT    = 4096;

   localparam logic [1:0] OP_VERTEX = 2'd0;
   localparam logic [1:0] OP_INDEX  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_UNSEEN = 2'd2;

   // floor(r / 3) == (r * DIV3_MUL) >> DIV3_SHIFT for every 14-bit r
   localparam logic [13:0] DIV3_MUL   = 14'd10923;
   localparam int          DIV3_SHIFT = 15;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [31:0] coord_x;
      logic [31:0] coord_y;
      logic [31:0] coord_z;
      logic [13:0] vertex_ref;
   } req_type;

   typedef struct packed {
      logic [11:0] mapped_index;
      logic        is_new;
      logic [31:0] out_x;
      logic [31:0] out_y;
      logic [31:0] out_z;
      logic [10:0] distinct_count;
      logic [1:0]  status;
   } rsp_type;

endpackage

// ===== hw/rtl/vertex_dedup_index_remap_top.sv =====
// Top level of the vertex dedup and index remap block.
`timescale 1ns / 1ps
//
// Welds duplicate vertices and remaps an index list.
// req_ channel: one beat per item (vertex, index remap, clear). rsp_ channel:
// exactly one result beat per item, in order.
// A vertex beat scans the distinct-vertex memory one entry per cycle through
// its single read port; a hit or the end of the scan settles the item, so
// the scan length sets the rate for vertex items. An index item steps
// through accept, divide by three and bounds check, record memory read and
// result; clear and unused opcodes go from accept straight to the result.
// The block holds one item at a time: req_stall is high from the accepting
// beat until the result moves into the output register.
// The output register parts the two sides: a finished result waits there
// while the next item is accepted and worked on. When rsp_stall holds the
// register and a second result is ready, that result waits in the control
// logic and req_stall stays high.
// Reset (synchronous, active high) empties the output register and zeroes
// the distinct and input counts; memory contents need no clearing since
// only entries below the counts are read. Clear zeroes both counts in one beat.
//
module vertex_dedup_index_remap_top
   import vdd_pkg::*;
#(
   parameter int MAX_DISTINCT       = DEF_MAX_DISTINCT,
   parameter int MAX_INPUT_VERTICES = DEF_MAX_INPUT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IW = $clog2(MAX_DISTINCT);
   localparam int DW = $clog2(MAX_DISTINCT + 1);
   localparam int AW = $clog2(MAX_INPUT_VERTICES);
   localparam int CW = $clog2(MAX_INPUT_VERTICES + 1);
   localparam int NW = (CW > 14) ? CW : 14;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_IDX   = 3'd3;
   localparam logic [2:0] S_IDXRD = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]    state_ff, state_in;
   req_type       item_ff, item_in;
   logic [IW-1:0] k_ff, k_in;
   logic [DW-1:0] dtot_ff, dtot_in;
   logic [CW-1:0] icnt_ff, icnt_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic          vtx_we, match;
   logic          rec_we;
   logic [AW-1:0] rec_raddr;
   logic [IW-1:0] rec_wdata, rec_rdata;
   logic [27:0]   div_prod;
   logic [13:0]   ref_n;
   rsp_type       zero_res;

   vdd_vtx_mem #(.DEPTH(MAX_DISTINCT), .IW(IW)) u_vtx (
      .clock   (clock),
      .wr_en   (vtx_we),
      .wr_addr (IW'(dtot_ff)),
      .rd_addr (k_in),
      .key_x   (item_ff.coord_x),
      .key_y   (item_ff.coord_y),
      .key_z   (item_ff.coord_z),
      .match   (match)
   );

   vdd_rec_mem #(.DEPTH(MAX_INPUT_VERTICES), .AW(AW), .IW(IW)) u_rec (
      .clock   (clock),
      .wr_en   (rec_we),
      .wr_addr (AW'(icnt_ff)),
      .wr_data (rec_wdata),
      .rd_addr (rec_raddr),
      .rd_data (rec_rdata)
   );

   // floor(vertex_ref / 3) by reciprocal multiply
   assign div_prod = 28'(item_ff.vertex_ref) * 28'(DIV3_MUL);
   assign ref_n    = 14'(div_prod >> DIV3_SHIFT);
   assign rec_raddr = AW'(ref_n);

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      zero_res                = '0;
      zero_res.distinct_count = 11'(dtot_ff);
      state_in     = state_ff;
      item_in      = item_ff;
      k_in         = k_ff;
      dtot_in      = dtot_ff;
      icnt_in      = icnt_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      vtx_we       = 1'b0;
      rec_we       = 1'b0;
      rec_wdata    = k_ff;

      case (state_ff)
         S_IDLE: begin
            k_in = '0;
            if (req_valid) begin
               item_in = req_data;
               res_in  = zero_res;
               case (req_data.opcode)
                  OP_VERTEX: begin
                     if (icnt_ff >= CW'(MAX_INPUT_VERTICES)) begin
                        res_in.status = ST_FULL;
                        state_in      = S_OUT;
                     end else if (dtot_ff == '0) begin
                        state_in = S_ADD;
                     end else begin
                        state_in = S_SCAN;
                     end
                  end
                  OP_INDEX: state_in = S_IDX;
                  OP_CLEAR: begin
                     dtot_in  = '0;
                     icnt_in  = '0;
                     res_in.distinct_count = '0;
                     state_in = S_OUT;
                  end
                  default: state_in = S_OUT;
               endcase
            end
         end
         S_SCAN: begin
            if (match) begin
               rec_we  = 1'b1;
               icnt_in = icnt_ff + 1'b1;
               res_in.mapped_index = 12'({1'b0, k_ff, 1'b0} + (IW + 2)'(k_ff));
               state_in = S_OUT;
            end else if ((DW'(k_ff) + 1'b1) == dtot_ff) begin
               state_in = S_ADD;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         S_ADD: begin
            if (dtot_ff >= DW'(MAX_DISTINCT)) begin
               res_in.status = ST_FULL;
            end else begin
               vtx_we    = 1'b1;
               rec_we    = 1'b1;
               rec_wdata = IW'(dtot_ff);
               dtot_in   = dtot_ff + 1'b1;
               icnt_in   = icnt_ff + 1'b1;
               res_in.mapped_index   = 12'({dtot_ff, 1'b0} + (DW + 1)'(dtot_ff));
               res_in.is_new         = 1'b1;
               res_in.out_x          = item_ff.coord_x;
               res_in.out_y          = item_ff.coord_y;
               res_in.out_z          = item_ff.coord_z;
               res_in.distinct_count = 11'(dtot_ff + 1'b1);
            end
            state_in = S_OUT;
         end
         S_IDX: begin
            // record read issues this cycle at rec_raddr
            if (NW'(ref_n) < NW'(icnt_ff)) begin
               state_in = S_IDXRD;
            end else begin
               res_in.status = ST_UNSEEN;
               state_in      = S_OUT;
            end
         end
         S_IDXRD: begin
            res_in.mapped_index = 12'({1'b0, rec_rdata, 1'b0} + (IW + 2)'(rec_rdata));
            state_in = S_OUT;
         end
         S_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         dtot_ff      <= '0;
         icnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dtot_ff      <= dtot_in;
         icnt_ff      <= icnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff <= item_in;
      k_ff    <= k_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule

// ===== hw/rtl/vdd_vtx_mem.sv =====
// Distinct-vertex memory with registered read and signed-zero aware key compare.
`timescale 1ns / 1ps

module vdd_vtx_mem #(
   parameter int DEPTH = 1024,
   parameter int IW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [IW-1:0] wr_addr,
   input  logic [IW-1:0] rd_addr,
   input  logic [31:0]   key_x,
   input  logic [31:0]   key_y,
   input  logic [31:0]   key_z,
   output logic          match
);

   logic [95:0] mem [DEPTH];
   logic [95:0] rd_data_ff;

   function automatic logic coord_eq(input logic [31:0] a, input logic [31:0] b);
      coord_eq = (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {key_x, key_y, key_z};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign match = coord_eq(rd_data_ff[95:64], key_x) &&
                  coord_eq(rd_data_ff[63:32], key_y) &&
                  coord_eq(rd_data_ff[31:0],  key_z);

endmodule

// ===== hw/rtl/vdd_rec_mem.sv =====
// Record memory: dense index of each input vertex, registered read.
`timescale 1ns / 1ps

module vdd_rec_mem #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int IW    = 10
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [IW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [IW-1:0] rd_data
);

   logic [IW-1:0] mem [DEPTH];
   logic [IW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the vertex dedup and index remap block.
`timescale 1ns / 1ps

module tb_top
   import vdd_pkg::*;
;

   localparam int MAXD = DEF_MAX_DISTINCT;
   localparam int MAXI = DEF_MAX_INPUT;
   localparam logic [1:0] OP_UNUSED = 2'd3;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   vertex_dedup_index_remap_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Predictor state: distinct vertex table, per-input dense index record.
   logic [31:0] weld_x [MAXD];
   logic [31:0] weld_y [MAXD];
   logic [31:0] weld_z [MAXD];
   logic [9:0]  dense_of [MAXI];
   int          n_distinct;
   int          n_inputs;

   rsp_type     pending_rsp[$];
   int          error_count;

   // Directed table: stimulus plus an optional typed-in expectation.
   typedef struct {
      req_type item;
      bit      has_fixed;
      rsp_type fixed;
   } vec_type;
   vec_type directed[$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #400ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic bit same_coord(logic [31:0] a, logic [31:0] b);
      return (a == b) || ((a[30:0] == 31'd0) && (b[30:0] == 31'd0));
   endfunction

   // Compute the expected result of one item and advance the predictor.
   function automatic rsp_type weld_predict(req_type r);
      rsp_type o;
      int      k;
      int      hit;
      int      n;
      o = '0;
      hit = -1;
      case (r.opcode)
         OP_VERTEX: begin
            if (n_inputs >= MAXI) begin
               o.status = ST_FULL;
            end else begin
               for (k = 0; k < n_distinct && hit < 0; k++)
                  if (same_coord(weld_x[k], r.coord_x) && same_coord(weld_y[k], r.coord_y)
                      && same_coord(weld_z[k], r.coord_z))
                     hit = k;
               if (hit >= 0) begin
                  dense_of[n_inputs] = hit[9:0];
                  n_inputs++;
                  o.mapped_index = 12'(3 * hit);
               end else if (n_distinct >= MAXD) begin
                  o.status = ST_FULL;
               end else begin
                  weld_x[n_distinct] = r.coord_x;
                  weld_y[n_distinct] = r.coord_y;
                  weld_z[n_distinct] = r.coord_z;
                  dense_of[n_inputs] = n_distinct[9:0];
                  n_inputs++;
                  o.mapped_index = 12'(3 * n_distinct);
                  o.is_new = 1'b1;
                  o.out_x = r.coord_x;
                  o.out_y = r.coord_y;
                  o.out_z = r.coord_z;
                  n_distinct++;
               end
            end
         end
         OP_INDEX: begin
            n = int'(r.vertex_ref) / 3;
            if (n >= n_inputs || n >= MAXI) o.status = ST_UNSEEN;
            else o.mapped_index = 12'(3 * int'(dense_of[n]));
         end
         OP_CLEAR: begin
            n_distinct = 0;
            n_inputs = 0;
         end
         default: ;
      endcase
      o.distinct_count = 11'(n_distinct);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Check accepted result beats against the oldest expectation.
   always @(posedge clock) begin
      rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected beat", 0, 0);
         end else begin
            w = pending_rsp.pop_front();
            if (rsp_data.mapped_index !== w.mapped_index)
               report_mismatch("mapped_index", 32'(rsp_data.mapped_index),
                               32'(w.mapped_index));
            if (rsp_data.is_new !== w.is_new)
               report_mismatch("is_new", 32'(rsp_data.is_new), 32'(w.is_new));
            if (rsp_data.out_x !== w.out_x) report_mismatch("out_x", rsp_data.out_x, w.out_x);
            if (rsp_data.out_y !== w.out_y) report_mismatch("out_y", rsp_data.out_y, w.out_y);
            if (rsp_data.out_z !== w.out_z) report_mismatch("out_z", rsp_data.out_z, w.out_z);
            if (rsp_data.distinct_count !== w.distinct_count)
               report_mismatch("distinct_count", 32'(rsp_data.distinct_count),
                               32'(w.distinct_count));
            if (rsp_data.status !== w.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(w.status));
         end
      end
   end

   // Receiver stall pattern: runs of free cycles, runs of random stalls.
   initial begin
      int mode;
      int run;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         run = $urandom_range(5, 120);
         repeat (run) begin
            @(posedge clock);
            case (mode)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 3) == 0);
               2: rsp_stall <= ($urandom_range(0, 1) == 0);
               default: rsp_stall <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Hold one beat on the bus until it is accepted; log the expectation.
   task automatic send_beat(req_type r, bit has_fixed, rsp_type fixed);
      rsp_type p;
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      p = weld_predict(r);
      if (has_fixed && p !== fixed) report_mismatch("directed row", p[31:0], fixed[31:0]);
      pending_rsp = {pending_rsp, p};
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
   endtask

   function automatic req_type mk(logic [1:0] op, logic [31:0] x, logic [31:0] y,
                                  logic [31:0] z, logic [13:0] vr);
      req_type r;
      r.opcode = op;
      r.coord_x = x;
      r.coord_y = y;
      r.coord_z = z;
      r.vertex_ref = vr;
      return r;
   endfunction

   function automatic rsp_type rs(logic [11:0] m, logic nw, logic [31:0] x, logic [31:0] y,
                                  logic [31:0] z, logic [10:0] dc, logic [1:0] st);
      rsp_type o;
      o.mapped_index = m;
      o.is_new = nw;
      o.out_x = x;
      o.out_y = y;
      o.out_z = z;
      o.distinct_count = dc;
      o.status = st;
      return o;
   endfunction

   function automatic void add_row(req_type r, bit f, rsp_type o);
      vec_type v;
      v.item = r;
      v.has_fixed = f;
      v.fixed = o;
      directed = {directed, v};
   endfunction

   // Random vertex drawn mostly from a small pool so that hits are common.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'h8000_0000;
         2, 3: return 32'h3f80_0000 + $urandom_range(0, 5);
         default: return $urandom();
      endcase
   endfunction

   initial begin
      req_type r;
      rsp_type none;
      int      burst;
      int      sent;
      int      i;
      int      waited;
      none = '0;
      error_count = 0;
      n_distinct = 0;
      n_inputs = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty table lookups, extremes, signed zero, clear, opcode 3.
      add_row(mk(OP_INDEX, 0, 0, 0, 14'd0), 1, rs(0, 0, 0, 0, 0, 0, ST_UNSEEN));
      add_row(mk(OP_VERTEX, 0, 0, 0, 0), 1, rs(0, 1, 0, 0, 0, 1, ST_OK));
      add_row(mk(OP_VERTEX, 32'h8000_0000, 32'h8000_0000, 0, 0), 1, rs(0, 0, 0, 0, 0, 1, ST_OK));
      add_row(mk(OP_VERTEX, '1, '1, '1, '1), 1, rs(3, 1, '1, '1, '1, 2, ST_OK));
      add_row(mk(OP_VERTEX, '1, '1, '1, 0), 1, rs(3, 0, 0, 0, 0, 2, ST_OK));
      add_row(mk(OP_VERTEX, 32'h7fc0_0000, 32'h8000_0001, 32'h1, 0), 0, none);
      add_row(mk(OP_INDEX, 0, 0, 0, 14'd3), 1, rs(0, 0, 0, 0, 0, 3, ST_OK));
      add_row(mk(OP_INDEX, 0, 0, 0, 14'd7), 1, rs(3, 0, 0, 0, 0, 3, ST_OK));
      add_row(mk(OP_INDEX, 0, 0, 0, 14'd11), 0, none);
      add_row(mk(OP_INDEX, '1, '1, '1, 14'd15), 1, rs(0, 0, 0, 0, 0, 3, ST_UNSEEN));
      add_row(mk(OP_INDEX, 0, 0, 0, 14'h3fff), 1, rs(0, 0, 0, 0, 0, 3, ST_UNSEEN));
      add_row(mk(OP_UNUSED, '1, '1, '1, '1), 1, rs(0, 0, 0, 0, 0, 3, ST_OK));
      add_row(mk(OP_CLEAR, '1, '1, '1, '1), 1, rs(0, 0, 0, 0, 0, 0, ST_OK));
      add_row(mk(OP_INDEX, 0, 0, 0, 14'd0), 1, rs(0, 0, 0, 0, 0, 0, ST_UNSEEN));
      add_row(mk(OP_VERTEX, 32'h8000_0000, 0, 32'h8000_0000, 0), 1,
              rs(0, 1, 32'h8000_0000, 0, 32'h8000_0000, 1, ST_OK));
      add_row(mk(OP_VERTEX, 0, 32'h8000_0000, 0, 0), 1, rs(0, 0, 0, 0, 0, 1, ST_OK));
      add_row(mk(OP_CLEAR, 0, 0, 0, 0), 1, rs(0, 0, 0, 0, 0, 0, ST_OK));
      foreach (directed[j]) begin
         send_beat(directed[j].item, directed[j].has_fixed, directed[j].fixed);
         if ($urandom_range(0, 2) == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 4)) @(posedge clock);
         end
      end

      // Fill pass: drive the table to full, then probe the record edges.
      for (i = 0; i < MAXD + 2; i++)
         send_beat(mk(OP_VERTEX, i, $urandom(), $urandom(), 0), 0, none);
      send_beat(mk(OP_INDEX, 0, 0, 0, 14'(3 * (MAXI - 1))), 0, none);
      send_beat(mk(OP_INDEX, 0, 0, 0, 14'(3 * MAXI)), 0, none);
      send_beat(mk(OP_INDEX, 0, 0, 0, 14'(3 * (MAXD - 1))), 0, none);
      send_beat(mk(OP_CLEAR, 0, 0, 0, 0), 0, none);

      // Hold the sender until the block has drained every result.
      drop_valid();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      // Random part: bursts of mostly vertex and index beats, rare clears.
      sent = 0;
      while (sent < 800) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            case ($urandom_range(0, 99)) inside
               [0:54]:  r = mk(OP_VERTEX, pick_coord(), pick_coord(), pick_coord(),
                               14'($urandom()));
               [55:89]: r = mk(OP_INDEX, $urandom(), $urandom(), $urandom(),
                               14'($urandom_range(0, 3 * (n_inputs + 3))));
               [90:94]: r = mk(OP_INDEX, $urandom(), $urandom(), $urandom(),
                               14'($urandom()));
               [95:97]: r = mk(OP_CLEAR, $urandom(), $urandom(), $urandom(),
                               14'($urandom()));
               default: r = mk(OP_UNUSED, $urandom(), $urandom(), $urandom(),
                               14'($urandom()));
            endcase
            send_beat(r, 0, none);
            sent++;
         end
         if ($urandom_range(0, 1) == 0) begin
            drop_valid();
            repeat ($urandom_range(1, 30)) @(posedge clock);
         end
      end
      drop_valid();

      // Drain with a bound, then let the pipeline settle.
      waited = 0;
      while (pending_rsp.size() != 0 && waited < 200000) begin
         @(posedge clock);
         waited++;
      end
      repeat (1100) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/vdd_pkg.sv
hw/rtl/vdd_vtx_mem.sv
hw/rtl/vdd_rec_mem.sv
hw/rtl/vertex_dedup_index_remap_top.sv
tb/sv/tb_top.sv
